// ===== rtl/core/bkvt_pkg.sv =====
`default_nettype none

package bkvt_pkg;

   localparam int DEPTH      = 16;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 32;

   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

   localparam int MODE_BITS  = 3;
   localparam int CSR_BITS   = 1;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ADD      = 3'd0,
      MODE_REMOVE   = 3'd1,
      MODE_CONTAINS = 3'd2,
      MODE_LOOKUP   = 3'd3,
      MODE_CLEAR    = 3'd4,
      MODE_STORE    = 3'd5
   } mode_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_AUTO_ADD      = 1'b0,
      CSR_DEFAULT_VALUE = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ===== rtl/core/bkvt_ifs.sv =====
`default_nettype none

interface bkvt_req_if import bkvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_in;

   modport source (output valid, output mode, output key_in, output value_in, input ready);
   modport sink   (input valid, input mode, input key_in, input value_in, output ready);
endinterface

interface bkvt_rsp_if import bkvt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [VALUE_BITS-1:0] value_out;
   logic [CNT_BITS-1:0]   entry_count;

   modport source (output valid, output ok, output value_out, output entry_count, input ready);
   modport sink   (input valid, input ok, input value_out, input entry_count, output ready);
endinterface

interface bkvt_csr_if import bkvt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_BITS-1:0]      index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bkvt_ram.sv =====
`default_nettype none

module bkvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [ADDR_BITS-1:0]    waddr,
   input  wire logic [WIDTH-1:0]        wdata,
   input  wire logic [ADDR_BITS-1:0]    raddr,
   output logic      [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/bounded_key_value_table.sv =====
// Key/value table of up to DEPTH entries held packed in insertion order in a
// single-port-read entry memory (key and value side by side). One request is
// worked at a time; a new one is taken as soon as the previous result sits in
// the output register, even if that result is not yet taken. Add, clear and
// unknown modes need no walk of the entries. Contains, lookup and store walk
// the entries one read per cycle and stop at the first match. Remove walks
// all count entries to find the last match, then moves each later entry down
// one place at one read and one write per cycle. The entry memory's single
// read port sets this pace. After reset the table is empty at once; no
// clearing pass runs.
`default_nettype none

module bounded_key_value_table import bkvt_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   bkvt_req_if.sink    req_ch,
   bkvt_rsp_if.source  rsp_ch,
   bkvt_csr_if.sink    csr_ch
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_RESOLVE = 5'b00100,
      ST_SHIFT   = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CNT_BITS-1:0]   scan_addr_ff, scan_addr_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   pend_addr_ff, pend_addr_in;
   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  ok_ff, ok_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic [CNT_BITS-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                  auto_add_ff;
   logic [VALUE_BITS-1:0] default_ff;

   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [IDX_BITS-1:0]   ram_raddr;
   logic [ENTRY_BITS-1:0] ram_rdata;

   logic                  req_fire;
   logic                  issue;
   logic                  room;
   logic                  key_match;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;

   bkvt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.value_out   = rsp_val_ff;
   assign rsp_ch.entry_count = rsp_cnt_ff;

   assign csr_ch.ready = 1'b1;

   assign rd_key    = ram_rdata[ENTRY_BITS-1:VALUE_BITS];
   assign rd_val    = ram_rdata[VALUE_BITS-1:0];
   assign issue     = (scan_addr_ff < cnt_ff);
   assign room      = (cnt_ff < CNT_BITS'(DEPTH));
   assign key_match = pend_ff && (rd_key == key_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      ok_in        = ok_ff;
      vout_in      = vout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff[IDX_BITS-1:0];
      ram_wdata    = {key_ff, val_ff};
      ram_raddr    = scan_addr_ff[IDX_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in      = req_ch.mode;
               key_in       = req_ch.key_in;
               val_in       = req_ch.value_in;
               ok_in        = 1'b0;
               vout_in      = '0;
               hit_in       = 1'b0;
               scan_addr_in = '0;
               pend_in      = 1'b0;
               state_in     = ST_DONE;
               case (req_ch.mode)
                  MODE_ADD: begin
                     if (room) begin
                        ram_we    = 1'b1;
                        ram_wdata = {req_ch.key_in, req_ch.value_in};
                        cnt_in    = cnt_ff + CNT_BITS'(1);
                        ok_in     = 1'b1;
                     end
                  end
                  MODE_REMOVE, MODE_CONTAINS, MODE_LOOKUP, MODE_STORE: begin
                     state_in = ST_SCAN;
                  end
                  MODE_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // one read issued per cycle, compared the cycle after
            pend_in = issue;
            if (issue) begin
               pend_addr_in = scan_addr_ff[IDX_BITS-1:0];
               scan_addr_in = scan_addr_ff + CNT_BITS'(1);
            end
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_addr_ff;
               hit_val_in = rd_val;
            end
            if (mode_ff == MODE_REMOVE) begin
               // keep the last match: walk to the end
               if (!pend_ff && !issue) begin
                  if (hit_ff) begin
                     scan_addr_in = CNT_BITS'(hit_idx_ff) + CNT_BITS'(1);
                     pend_in      = 1'b0;
                     state_in     = ST_SHIFT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end else if (key_match || (!pend_ff && !issue)) begin
               state_in = ST_RESOLVE;
            end
         end

         ST_RESOLVE: begin
            state_in = ST_DONE;
            case (mode_ff)
               MODE_CONTAINS: begin
                  ok_in = hit_ff;
               end
               MODE_LOOKUP: begin
                  if (hit_ff) begin
                     ok_in   = 1'b1;
                     vout_in = hit_val_ff;
                  end else if (auto_add_ff && room) begin
                     ram_we    = 1'b1;
                     ram_wdata = {key_ff, default_ff};
                     cnt_in    = cnt_ff + CNT_BITS'(1);
                     ok_in     = 1'b1;
                     vout_in   = default_ff;
                  end
               end
               MODE_STORE: begin
                  if (hit_ff) begin
                     ram_we    = 1'b1;
                     ram_waddr = hit_idx_ff;
                     ok_in     = 1'b1;
                  end else if (auto_add_ff && room) begin
                     ram_we = 1'b1;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                     ok_in  = 1'b1;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end

         ST_SHIFT: begin
            // read entry j, write it to j-1 the next cycle
            pend_in = issue;
            if (issue) begin
               pend_addr_in = scan_addr_ff[IDX_BITS-1:0];
               scan_addr_in = scan_addr_ff + CNT_BITS'(1);
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff - IDX_BITS'(1);
               ram_wdata = ram_rdata;
            end
            if (!pend_ff && !issue) begin
               cnt_in   = cnt_ff - CNT_BITS'(1);
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_val_in   = vout_ff;
               rsp_cnt_in   = cnt_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      scan_addr_ff <= scan_addr_in;
      pend_ff      <= pend_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_val_ff   <= hit_val_in;
      ok_ff        <= ok_in;
      vout_ff      <= vout_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_add_ff <= 1'b0;
         default_ff  <= '0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_AUTO_ADD: begin
               auto_add_ff <= csr_ch.data[0];
            end
            CSR_DEFAULT_VALUE: begin
               default_ff <= csr_ch.data[VALUE_BITS-1:0];
            end
            default: begin
               auto_add_ff <= auto_add_ff;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above capacity");

   a_shift_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && ram_we |-> (CNT_BITS'(ram_waddr) < cnt_ff))
      else $error("shift writes outside the packed entries");

   a_add_full_holds: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.mode == MODE_ADD) && !room |=> cnt_ff == $past(cnt_ff))
      else $error("add on a full table changed the count");

   a_shift_end_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) && (state_in == ST_DONE)
      |=> cnt_ff == $past(cnt_ff) - CNT_BITS'(1))
      else $error("remove did not drop exactly one entry");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("entry memory written during a search");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench import bkvt_pkg::*; ();

   localparam int CYCLE_LIMIT = 600_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int BACKPRESSURE_CYCLES = 300;
   localparam int KEY_POOL_SIZE = 6;

   // modes the block has no meaning for; they must leave the table alone
   localparam logic [MODE_BITS-1:0] MODE_RESERVED_6 = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_RESERVED_7 = 3'd7;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } table_req_type;

   typedef struct packed {
      logic                  ok;
      logic [VALUE_BITS-1:0] value;
      logic [CNT_BITS-1:0]   count;
   } table_rsp_type;

   class kv_scoreboard;
      logic [KEY_BITS-1:0]   keys[DEPTH];
      logic [VALUE_BITS-1:0] vals[DEPTH];
      int                    fill;
      bit                    auto_add;
      logic [VALUE_BITS-1:0] default_value;
      table_rsp_type         pending_rsp[$];
      int                    fail_count;

      function new();
         fill = 0;
         auto_add = 0;
         default_value = '0;
         fail_count = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_AUTO_ADD) begin
            auto_add = data[0];
         end else begin
            default_value = data[VALUE_BITS-1:0];
         end
      endfunction

      function int first_hit(logic [KEY_BITS-1:0] k);
         for (int i = 0; i < fill; i++) begin
            if (keys[i] == k) begin
               return i;
            end
         end
         return -1;
      endfunction

      // lookup and store path: a miss may append the key with the default value
      function int resolve_slot(logic [KEY_BITS-1:0] k);
         int s;
         s = first_hit(k);
         if (s >= 0) begin
            return s;
         end
         if (auto_add && fill < DEPTH) begin
            keys[fill] = k;
            vals[fill] = default_value;
            fill++;
            return fill - 1;
         end
         return -1;
      endfunction

      function void note_request(table_req_type r);
         table_rsp_type e;
         int            slot;
         e = '0;
         case (r.mode)
            MODE_ADD: begin
               if (fill < DEPTH) begin
                  keys[fill] = r.key;
                  vals[fill] = r.value;
                  fill++;
                  e.ok = 1'b1;
               end
            end
            MODE_REMOVE: begin
               // drop the last match, then close the gap
               slot = -1;
               for (int i = 0; i < fill; i++) begin
                  if (keys[i] == r.key) begin
                     slot = i;
                  end
               end
               if (slot >= 0) begin
                  for (int i = slot; i + 1 < fill; i++) begin
                     keys[i] = keys[i+1];
                     vals[i] = vals[i+1];
                  end
                  fill--;
                  e.ok = 1'b1;
               end
            end
            MODE_CONTAINS: begin
               e.ok = (first_hit(r.key) >= 0);
            end
            MODE_LOOKUP: begin
               slot = resolve_slot(r.key);
               if (slot >= 0) begin
                  e.ok = 1'b1;
                  e.value = vals[slot];
               end
            end
            MODE_CLEAR: begin
               fill = 0;
               e.ok = 1'b1;
            end
            MODE_STORE: begin
               slot = resolve_slot(r.key);
               if (slot >= 0) begin
                  vals[slot] = r.value;
                  e.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         e.count = CNT_BITS'(fill);
         pending_rsp.push_back(e);
      endfunction

      function void check_response(table_rsp_type got);
         table_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result: ok=%0d value_out=%h entry_count=%0d",
                   got.ok, got.value, got.count);
            fail_count++;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.ok !== e.ok) begin
            $error("ok mismatch: expected %0d, got %0d", e.ok, got.ok);
            fail_count++;
         end
         if (got.value !== e.value) begin
            $error("value_out mismatch: expected %h, got %h", e.value, got.value);
            fail_count++;
         end
         if (got.count !== e.count) begin
            $error("entry_count mismatch: expected %0d, got %0d", e.count, got.count);
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bkvt_req_if req_bus ();
   bkvt_rsp_if rsp_bus ();
   bkvt_csr_if csr_bus ();

   bounded_key_value_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   kv_scoreboard        sb;
   int unsigned         req_idle_pct;
   int unsigned         rsp_stall_pct;
   logic                hold_rsp;
   int                  cycle_count = 0;
   logic [KEY_BITS-1:0] key_pool[KEY_POOL_SIZE];

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL bounded_key_value_table");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_response('{ok: rsp_bus.ok, value: rsp_bus.value_out,
                             count: rsp_bus.entry_count});
      end
   end

   function automatic table_req_type req_item(logic [MODE_BITS-1:0] mode,
                                              logic [KEY_BITS-1:0] key,
                                              logic [VALUE_BITS-1:0] value);
      table_req_type r;
      r.mode = mode;
      r.key = key;
      r.value = value;
      return r;
   endfunction

   function automatic table_req_type random_request();
      table_req_type r;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.mode = MODE_ADD;
      end else if (pick < 45) begin
         r.mode = MODE_REMOVE;
      end else if (pick < 57) begin
         r.mode = MODE_CONTAINS;
      end else if (pick < 75) begin
         r.mode = MODE_LOOKUP;
      end else if (pick < 93) begin
         r.mode = MODE_STORE;
      end else if (pick < 96) begin
         r.mode = MODE_CLEAR;
      end else begin
         r.mode = pick[0] ? MODE_RESERVED_7 : MODE_RESERVED_6;
      end
      // a small key pool keeps hits and duplicate keys frequent
      if ($urandom_range(0, 99) < 75) begin
         r.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      end else begin
         r.key = KEY_BITS'($urandom);
      end
      r.value = $urandom;
      return r;
   endfunction

   // leaves valid high after the transfer; the next call or idle_req decides
   task automatic put_request(table_req_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= r.mode;
      req_bus.key_in <= r.key;
      req_bus.value_in <= r.value;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
   endtask

   task automatic idle_req();
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain_results();
      idle_req();
      while (sb.pending_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_register(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         put_request(random_request());
      end
   endtask

   initial begin
      sb = new();
      hold_rsp = 1'b0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++) begin
         key_pool[i] = KEY_BITS'($urandom);
      end
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_ADD;
      req_bus.key_in <= '0;
      req_bus.value_in <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_AUTO_ADD;
      csr_bus.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, auto-add off: every miss is a plain miss
      put_request(req_item(MODE_LOOKUP, 16'h1234, 32'h0));
      put_request(req_item(MODE_CONTAINS, 16'h1234, 32'h0));
      put_request(req_item(MODE_REMOVE, 16'h1234, 32'h0));
      put_request(req_item(MODE_STORE, 16'h1234, 32'hDEADBEEF));
      put_request(req_item(MODE_ADD, 16'h0000, 32'h0000_0000));
      put_request(req_item(MODE_ADD, 16'hFFFF, 32'hFFFF_FFFF));
      put_request(req_item(MODE_ADD, 16'h0000, 32'h1234_5678));
      put_request(req_item(MODE_LOOKUP, 16'h0000, 32'h0));
      put_request(req_item(MODE_STORE, 16'h0000, 32'hAAAA_5555));
      put_request(req_item(MODE_REMOVE, 16'h0000, 32'h0));
      put_request(req_item(MODE_CONTAINS, 16'hFFFF, 32'h0));
      put_request(req_item(MODE_RESERVED_6, 16'h0000, 32'h0));
      put_request(req_item(MODE_RESERVED_7, 16'hFFFF, 32'hFFFF_FFFF));
      for (int i = 0; i < DEPTH - 2; i++) begin
         put_request(req_item(MODE_ADD, KEY_BITS'(16'h0100 + i), $urandom));
      end
      put_request(req_item(MODE_ADD, 16'h5A5A, 32'h5A5A_5A5A));
      put_request(req_item(MODE_CLEAR, 16'h0000, 32'h0));
      drain_results();

      write_csr(CSR_AUTO_ADD, 32'd1);
      write_csr(CSR_DEFAULT_VALUE, 32'hFFFF_FFFF);
      put_request(req_item(MODE_LOOKUP, 16'h0BEE, 32'h0));
      put_request(req_item(MODE_STORE, 16'h0C0D, 32'h1357_9BDF));
      put_request(req_item(MODE_LOOKUP, 16'h0C0D, 32'h0));
      run_random(400);
      drain_results();

      write_csr(CSR_AUTO_ADD, 32'd0);
      write_csr(CSR_DEFAULT_VALUE, 32'd0);
      req_idle_pct = 83;
      run_random(300);
      drain_results();

      write_csr(CSR_AUTO_ADD, 32'd1);
      write_csr(CSR_DEFAULT_VALUE, $urandom);
      req_idle_pct = 0;
      rsp_stall_pct <= 83;
      // hold off the result side so the block backs up into the request side
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (BACKPRESSURE_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         run_random(300);
      join
      drain_results();

      write_csr(CSR_DEFAULT_VALUE, 32'd0);
      req_idle_pct = 30;
      rsp_stall_pct <= 30;
      run_random(150);
      drain_results();
      run_random(150);
      drain_results();

      write_csr(CSR_AUTO_ADD, 32'd0);
      write_csr(CSR_DEFAULT_VALUE, $urandom);
      req_idle_pct = 0;
      rsp_stall_pct <= 0;
      run_random(220);
      drain_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending_rsp.size() != 0) begin
         $error("%0d results never arrived", sb.pending_rsp.size());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("PASS bounded_key_value_table");
      end else begin
         $display("FAIL bounded_key_value_table");
      end
      $finish;
   end

endmodule
